// ===== design/rppg_pkg.sv =====
package rppg_pkg;

    localparam int MAX_RINGS    = 60;
    localparam int DEGREES      = 360;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;

    // divider passes: full semi-height for the apex, 15-bit 60*j for a ring point
    localparam int DIV_BITS_AP = 24;
    localparam int DIV_BITS_PT = 15;

    localparam logic [2:0] CFG_RING_COUNT  = 3'd0;
    localparam logic [2:0] CFG_SEMI_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_APEX_X      = 3'd2;
    localparam logic [2:0] CFG_APEX_Y      = 3'd3;
    localparam logic [2:0] CFG_APEX_Z      = 3'd4;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [3:0] t_op;
    typedef logic [2:0] t_jc;

    localparam t_op OP_IDLE     = 4'd0;
    localparam t_op OP_NONE     = 4'd1;
    localparam t_op OP_PT_DIVLD = 4'd2;
    localparam t_op OP_MUL_X    = 4'd3;
    localparam t_op OP_ADD_X    = 4'd4;
    localparam t_op OP_MUL_Y    = 4'd5;
    localparam t_op OP_PT_OUT   = 4'd6;
    localparam t_op OP_AP_DIVLD = 4'd7;
    localparam t_op OP_AP_OUT   = 4'd8;

    localparam t_jc JC_NEXT     = 3'd0;
    localparam t_jc JC_ALWAYS   = 3'd1;
    localparam t_jc JC_NO_REQ   = 3'd2;
    localparam t_jc JC_APEX     = 3'd3;
    localparam t_jc JC_DIV_BUSY = 3'd4;
    localparam t_jc JC_OUT_BUSY = 3'd5;

    localparam t_step ST_WAIT   = 4'd0;
    localparam t_step ST_DECIDE = 4'd1;
    localparam t_step ST_PT_LD  = 4'd2;
    localparam t_step ST_PT_DIV = 4'd3;
    localparam t_step ST_MUL_X  = 4'd4;
    localparam t_step ST_ADD_X  = 4'd5;
    localparam t_step ST_MUL_Y  = 4'd6;
    localparam t_step ST_PT_OUT = 4'd7;
    localparam t_step ST_AP_LD  = 4'd8;
    localparam t_step ST_AP_DIV = 4'd9;
    localparam t_step ST_AP_OUT = 4'd10;

    typedef struct packed {
        t_op   op;
        t_jc   jc;
        t_step target;
        logic  fin;
    } t_ctl;

    typedef struct packed {
        logic req;
        logic apex;
        logic div_busy;
        logic out_busy;
    } t_stat;

    localparam logic [15:0] QUARTER_SINE [0:90] = '{
        16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
        16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
        16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
        16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
        16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
        16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
        16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
        16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
        16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
        16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
        16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
    };

    function automatic logic signed [15:0] sine_q15(input logic [8:0] d);
        logic [7:0] m;
        logic [6:0] idx;
        logic [15:0] v;
        m = (d >= 9'(HALF_TURN)) ? 8'(d - 9'(HALF_TURN)) : d[7:0];
        idx = (m <= 8'(QUARTER_TURN)) ? m[6:0] : 7'(8'(HALF_TURN) - m);
        v = QUARTER_SINE[idx];
        sine_q15 = (d >= 9'(HALF_TURN)) ? 16'(-v) : v;
    endfunction

    // control store
    function automatic t_ctl micro_rom(input t_step s);
        t_ctl c;
        unique case (s)
            ST_WAIT:   c = '{op: OP_IDLE,     jc: JC_NO_REQ,   target: ST_WAIT,   fin: 1'b0};
            ST_DECIDE: c = '{op: OP_NONE,     jc: JC_APEX,     target: ST_AP_LD,  fin: 1'b0};
            ST_PT_LD:  c = '{op: OP_PT_DIVLD, jc: JC_NEXT,     target: ST_WAIT,   fin: 1'b0};
            ST_PT_DIV: c = '{op: OP_NONE,     jc: JC_DIV_BUSY, target: ST_PT_DIV, fin: 1'b0};
            ST_MUL_X:  c = '{op: OP_MUL_X,    jc: JC_NEXT,     target: ST_WAIT,   fin: 1'b0};
            ST_ADD_X:  c = '{op: OP_ADD_X,    jc: JC_NEXT,     target: ST_WAIT,   fin: 1'b0};
            ST_MUL_Y:  c = '{op: OP_MUL_Y,    jc: JC_NEXT,     target: ST_WAIT,   fin: 1'b0};
            ST_PT_OUT: c = '{op: OP_PT_OUT,   jc: JC_OUT_BUSY, target: ST_PT_OUT, fin: 1'b1};
            ST_AP_LD:  c = '{op: OP_AP_DIVLD, jc: JC_NEXT,     target: ST_WAIT,   fin: 1'b0};
            ST_AP_DIV: c = '{op: OP_NONE,     jc: JC_DIV_BUSY, target: ST_AP_DIV, fin: 1'b0};
            ST_AP_OUT: c = '{op: OP_AP_OUT,   jc: JC_OUT_BUSY, target: ST_AP_OUT, fin: 1'b1};
            default:   c = '{op: OP_NONE,     jc: JC_ALWAYS,   target: ST_WAIT,   fin: 1'b0};
        endcase
        micro_rom = c;
    endfunction

endpackage

// ===== design/rppg_div.sv =====
module rppg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [6:0]  i_divisor,
    input  logic [4:0]  i_last_cnt,
    output logic        o_busy,
    output logic [23:0] o_quot
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [5:0]  r_rem;
    logic [23:0] r_quo;
    logic [6:0]  r_dvs;

    logic        n_busy;
    logic [4:0]  n_cnt;
    logic [5:0]  n_rem;
    logic [23:0] n_quo;
    logic [6:0]  trial;
    logic        fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[23]};
        fits = (trial >= r_dvs);
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = i_last_cnt;
            n_rem = '0;
            n_quo = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? 6'(trial - r_dvs) : trial[5:0];
            n_quo = {r_quo[22:0], fits};
            n_cnt = r_cnt - 5'd1;
            n_busy = (r_cnt != 5'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

// ===== design/rppg_seq.sv =====
module rppg_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rppg_pkg::t_stat i_stat,
    output rppg_pkg::t_ctl  o_ctl
);

    rppg_pkg::t_step r_step;
    rppg_pkg::t_step n_step;
    rppg_pkg::t_ctl  ctl;
    logic            take;

    assign ctl = rppg_pkg::micro_rom(r_step);

    always_comb begin
        unique case (ctl.jc)
            rppg_pkg::JC_NEXT:     take = 1'b0;
            rppg_pkg::JC_ALWAYS:   take = 1'b1;
            rppg_pkg::JC_NO_REQ:   take = !i_stat.req;
            rppg_pkg::JC_APEX:     take = i_stat.apex;
            rppg_pkg::JC_DIV_BUSY: take = i_stat.div_busy;
            rppg_pkg::JC_OUT_BUSY: take = i_stat.out_busy;
            default:               take = 1'b1;
        endcase
        priority if (take) begin
            n_step = ctl.target;
        end else if (ctl.fin) begin
            n_step = rppg_pkg::ST_WAIT;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rppg_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = ctl;

endmodule

// ===== design/ring_pupil_point_generator_top.sv =====
// Ring pupil point generator. Each request on the input stream yields one point of a
// ring pattern over a circular aperture: the apex first, then 6k points on ring k for
// k = 1..ring_count (ring_count clamped to 1..MAX_RINGS), the last one flagged with
// tlast, after which the pattern wraps to the apex. A request with restart set emits
// the apex at once. A short microcode program steps a bit-serial divider and one
// 16x31 multiplier. A ring point passes the steps load, divide, multiply x, add x,
// multiply y and output, an apex the steps load, divide and output; the divider forms
// a 15-bit quotient for the spoke angle and a 24-bit one for the ring spacing. After
// the output step the sequencer waits for the next request. The result sits in an
// output register, so the next request is taken while it waits; a result still
// waiting holds the sequencer at its output step. Configuration writes are taken at
// any time but belong between patterns; semi_height and ring_count take effect for the spacing at the next apex.
module ring_pupil_point_generator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [0] restart
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,   // point_x, point_y, point_z, ring_number, spoke_degree
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    logic [5:0]  r_ring_count;
    logic [23:0] r_semi;
    logic [31:0] r_apex_x;
    logic [31:0] r_apex_y;
    logic [31:0] r_apex_z;

    logic        r_restart;
    logic [5:0]  r_ring;
    logic [8:0]  r_spoke;
    logic [23:0] r_rstep;
    logic [29:0] r_acc;
    logic [8:0]  r_deg;
    logic signed [46:0] r_prod;
    logic [31:0] r_px;

    logic        r_ovalid;
    logic [31:0] r_ox;
    logic [31:0] r_oy;
    logic [31:0] r_oz;
    logic [5:0]  r_oring;
    logic [8:0]  r_odeg;
    logic        r_olast;

    rppg_pkg::t_ctl  ctl;
    rppg_pkg::t_stat stat;

    logic        in_fire;
    logic        out_busy;
    logic        do_pt_out;
    logic        do_ap_out;
    logic [5:0]  rings_used;
    logic [14:0] sixty_j;
    logic        div_start;
    logic        div_ap;
    logic [23:0] div_dividend;
    logic [6:0]  div_divisor;
    logic [4:0]  div_last;
    logic        div_busy;
    logic [23:0] div_quot;
    logic [8:0]  cos_deg;
    logic signed [15:0] trig;
    logic signed [30:0] radius;
    logic signed [46:0] prod_w;
    logic [8:0]  six_k;
    logic [9:0]  spoke_inc;
    logic        ring_end;
    logic        is_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count <= 6'd3;
            r_semi <= 24'd256;
            r_apex_x <= '0;
            r_apex_y <= '0;
            r_apex_z <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rppg_pkg::CFG_RING_COUNT:  r_ring_count <= i_cfg_data[5:0];
                rppg_pkg::CFG_SEMI_HEIGHT: r_semi <= i_cfg_data[23:0];
                rppg_pkg::CFG_APEX_X:      r_apex_x <= i_cfg_data;
                rppg_pkg::CFG_APEX_Y:      r_apex_y <= i_cfg_data;
                rppg_pkg::CFG_APEX_Z:      r_apex_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rppg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    rppg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_last_cnt (div_last),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign o_s_tready = (ctl.op == rppg_pkg::OP_IDLE);
    assign in_fire = i_s_tvalid && o_s_tready;
    assign out_busy = r_ovalid && !i_m_tready;

    assign stat = '{req: i_s_tvalid,
                    apex: r_restart || (r_ring == 6'd0),
                    div_busy: div_busy,
                    out_busy: out_busy};

    assign do_pt_out = (ctl.op == rppg_pkg::OP_PT_OUT) && !out_busy;
    assign do_ap_out = (ctl.op == rppg_pkg::OP_AP_OUT) && !out_busy;

    // ring count clamped to 1..MAX_RINGS
    assign rings_used = (r_ring_count == 6'd0) ? 6'd1 :
                        (r_ring_count > 6'(rppg_pkg::MAX_RINGS)) ?
                        6'(rppg_pkg::MAX_RINGS) : r_ring_count;

    assign sixty_j = 15'({r_spoke, 6'b0}) - 15'({r_spoke, 2'b0});
    assign div_ap = (ctl.op == rppg_pkg::OP_AP_DIVLD);
    assign div_start = div_ap || (ctl.op == rppg_pkg::OP_PT_DIVLD);
    assign div_dividend = div_ap ? r_semi : {sixty_j, 9'b0};
    assign div_divisor = div_ap ? (7'(rings_used) + 7'd1) : {1'b0, r_ring};
    assign div_last = div_ap ? 5'(rppg_pkg::DIV_BITS_AP - 1) : 5'(rppg_pkg::DIV_BITS_PT - 1);

    // cosine through the sine table, a quarter turn ahead
    assign cos_deg = (r_deg >= 9'(rppg_pkg::DEGREES - rppg_pkg::QUARTER_TURN)) ?
                     (r_deg - 9'(rppg_pkg::DEGREES - rppg_pkg::QUARTER_TURN)) :
                     (r_deg + 9'(rppg_pkg::QUARTER_TURN));
    assign trig = (ctl.op == rppg_pkg::OP_MUL_Y) ? rppg_pkg::sine_q15(cos_deg) :
                  rppg_pkg::sine_q15(div_quot[8:0]);
    assign radius = {1'b0, r_acc};
    assign prod_w = trig * radius;

    assign six_k = 9'({r_ring, 2'b0}) + 9'({r_ring, 1'b0});
    assign spoke_inc = 10'(r_spoke) + 10'd1;
    assign ring_end = (spoke_inc >= 10'(six_k));
    assign is_last = ring_end && (r_ring >= rings_used);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= 1'b0;
            r_ring <= '0;
            r_spoke <= '0;
            r_rstep <= '0;
            r_acc <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_restart <= i_s_tdata[0];
            end
            if (do_ap_out || do_pt_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (do_ap_out) begin
                r_rstep <= div_quot;
                r_acc <= 30'(div_quot);
                r_ring <= 6'd1;
                r_spoke <= '0;
            end else if (do_pt_out) begin
                if (ring_end) begin
                    r_spoke <= '0;
                    if (is_last) begin
                        r_ring <= '0;
                    end else begin
                        r_ring <= r_ring + 6'd1;
                        r_acc <= r_acc + 30'(r_rstep);
                    end
                end else begin
                    r_spoke <= spoke_inc[8:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.op == rppg_pkg::OP_MUL_X) begin
            r_deg <= div_quot[8:0];
        end
        if (ctl.op == rppg_pkg::OP_MUL_X || ctl.op == rppg_pkg::OP_MUL_Y) begin
            r_prod <= prod_w;
        end
        if (ctl.op == rppg_pkg::OP_ADD_X) begin
            r_px <= r_apex_x + r_prod[46:15];
        end
        if (do_ap_out) begin
            r_ox <= r_apex_x;
            r_oy <= r_apex_y;
            r_oz <= r_apex_z;
            r_oring <= '0;
            r_odeg <= '0;
            r_olast <= 1'b0;
        end else if (do_pt_out) begin
            r_ox <= r_px;
            r_oy <= r_apex_y + r_prod[46:15];
            r_oz <= r_apex_z;
            r_oring <= r_ring;
            r_odeg <= r_deg;
            r_olast <= is_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata = {1'b0, r_odeg, r_oring, r_oz, r_oy, r_ox};
    assign o_m_tlast = r_olast;

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring <= 6'(rppg_pkg::MAX_RINGS))
        else $error("ring counter out of range");

    a_spoke_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring != 6'd0) |-> (10'(r_spoke) < 10'(six_k)))
        else $error("spoke counter past end of ring");

    a_last_on_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (r_oring != 6'd0))
        else $error("apex flagged as last point");

    a_apex_starts_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ap_out |=> (r_ring == 6'd1 && r_spoke == 9'd0 && o_m_tvalid))
        else $error("apex did not start ring one");

endmodule

// ===== verif/tb_ring_pupil_point_generator_top.sv =====
`timescale 1ns / 1ps

module tb_ring_pupil_point_generator_top;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 40;

    localparam int QUARTER_WAVE [0:90] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32767
    };

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  ring;
        logic [8:0]  deg;
        logic        is_last;
    } t_pupil_point;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata = 8'd0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [111:0] o_m_tdata;
    logic         o_m_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = 3'd0;
    logic [31:0]  i_cfg_data = 32'd0;

    // register copies and pattern state of the predictor
    logic [5:0]  cfg_rings = 6'd3;
    logic [23:0] cfg_semi = 24'd256;
    logic [31:0] cfg_apex_x = 32'd0;
    logic [31:0] cfg_apex_y = 32'd0;
    logic [31:0] cfg_apex_z = 32'd0;
    int unsigned ring_at = 0;
    int unsigned spoke_at = 0;
    logic [23:0] step_len = 24'd0;
    logic [29:0] radius = 30'd0;

    t_pupil_point pending_points [$];
    int error_count = 0;
    int cycle_count = 0;
    bit src_gaps = 1'b0;
    bit sink_stalls = 1'b0;

    ring_pupil_point_generator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sine_of(input int unsigned d);
        int unsigned m;
        int v;
        m = d % rppg_pkg::HALF_TURN;
        v = QUARTER_WAVE[(m <= rppg_pkg::QUARTER_TURN) ? m : rppg_pkg::HALF_TURN - m];
        return (d < rppg_pkg::HALF_TURN) ? v : -v;
    endfunction

    // base + floor(s * r / 2^15), wrapping at 32 bits
    function automatic logic [31:0] shift_coord(input logic [31:0] base, input int s,
                                                input logic [29:0] r);
        longint prod;
        longint q;
        prod = longint'(s) * longint'(r);
        q = prod >>> 15;
        return base + q[31:0];
    endfunction

    function automatic t_pupil_point advance_pattern(input logic restart);
        t_pupil_point p;
        int unsigned n;
        int unsigned deg;
        n = cfg_rings;
        if (n < 1) n = 1;
        if (n > rppg_pkg::MAX_RINGS) n = rppg_pkg::MAX_RINGS;
        p.z = cfg_apex_z;
        p.is_last = 1'b0;
        if (restart || ring_at == 0) begin
            step_len = 24'(cfg_semi / (n + 1));
            radius = 30'(step_len);
            ring_at = 1;
            spoke_at = 0;
            p.x = cfg_apex_x;
            p.y = cfg_apex_y;
            p.ring = 6'd0;
            p.deg = 9'd0;
        end else begin
            deg = (60 * spoke_at / ring_at) % rppg_pkg::DEGREES;
            p.x = shift_coord(cfg_apex_x, sine_of(deg), radius);
            p.y = shift_coord(cfg_apex_y,
                              sine_of((deg + rppg_pkg::QUARTER_TURN) % rppg_pkg::DEGREES),
                              radius);
            p.ring = 6'(ring_at);
            p.deg = 9'(deg);
            if (spoke_at + 1 >= 6 * ring_at) begin
                spoke_at = 0;
                if (ring_at >= n) begin
                    p.is_last = 1'b1;
                    ring_at = 0;
                end else begin
                    ring_at = ring_at + 1;
                    radius = radius + 30'(step_len);
                end
            end else begin
                spoke_at = spoke_at + 1;
            end
        end
        return p;
    endfunction

    task automatic send_request(input logic restart);
        @(negedge i_clk);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, restart};
        do @(posedge i_clk); while (!o_s_tready);
        pending_points = {pending_points, advance_pattern(restart)};
    endtask

    task automatic drain_points();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        unique case (idx)
            rppg_pkg::CFG_RING_COUNT:  cfg_rings = val[5:0];
            rppg_pkg::CFG_SEMI_HEIGHT: cfg_semi = val[23:0];
            rppg_pkg::CFG_APEX_X:      cfg_apex_x = val;
            rppg_pkg::CFG_APEX_Y:      cfg_apex_y = val;
            rppg_pkg::CFG_APEX_Z:      cfg_apex_z = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // reset values: three rings, first request yields the apex without restart
    task automatic test_reset_defaults();
        repeat (6) send_request(1'b0);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
    endtask

    // one ring at maximum semi-height, apex at the wrap corners
    task automatic test_single_ring();
        drain_points();
        write_reg(rppg_pkg::CFG_RING_COUNT, 32'd1);
        write_reg(rppg_pkg::CFG_SEMI_HEIGHT, 32'h00FF_FFFF);
        write_reg(rppg_pkg::CFG_APEX_X, 32'h7FFF_FFFF);
        write_reg(rppg_pkg::CFG_APEX_Y, 32'h8000_0000);
        write_reg(rppg_pkg::CFG_APEX_Z, 32'hFFFF_FFFF);
        send_request(1'b1);
        repeat (7) send_request(1'b0);
    endtask

    // zero rings behaves as one, zero semi-height gives zero radius
    task automatic test_zero_rings();
        drain_points();
        write_reg(rppg_pkg::CFG_RING_COUNT, 32'd0);
        write_reg(rppg_pkg::CFG_SEMI_HEIGHT, 32'd0);
        write_reg(rppg_pkg::CFG_APEX_X, 32'hFFFF_FF00);
        write_reg(rppg_pkg::CFG_APEX_Y, 32'd0);
        write_reg(rppg_pkg::CFG_APEX_Z, 32'h8000_0000);
        send_request(1'b1);
        repeat (7) send_request(1'b0);
    endtask

    // semi-height written mid-pattern only applies at the next apex
    task automatic test_semi_latch();
        drain_points();
        write_reg(rppg_pkg::CFG_RING_COUNT, 32'd2);
        write_reg(rppg_pkg::CFG_SEMI_HEIGHT, 32'd90000);
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        drain_points();
        write_reg(rppg_pkg::CFG_SEMI_HEIGHT, 32'd12345);
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
    endtask

    // ring count lowered inside ring 2: ring 2 finishes and is flagged last
    task automatic test_lowered_rings();
        drain_points();
        write_reg(rppg_pkg::CFG_RING_COUNT, 32'd3);
        write_reg(rppg_pkg::CFG_SEMI_HEIGHT, 32'd3000);
        write_reg(rppg_pkg::CFG_APEX_X, 32'd1000);
        write_reg(rppg_pkg::CFG_APEX_Y, -32'sd2000);
        write_reg(rppg_pkg::CFG_APEX_Z, 32'd77);
        send_request(1'b1);
        repeat (10) send_request(1'b0);
        drain_points();
        write_reg(rppg_pkg::CFG_RING_COUNT, 32'd1);
        repeat (10) send_request(1'b0);
    endtask

    task automatic test_random_patterns();
        int sent;
        int burst;
        logic [31:0] semi;
        sent = 0;
        while (sent < 400) begin
            drain_points();
            src_gaps = ($urandom_range(0, 2) != 0);
            sink_stalls = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(rppg_pkg::CFG_RING_COUNT, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 63) : $urandom_range(1, 4));
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: semi = $urandom & 32'h00FF_FFFF;
                    1: semi = $urandom_range(0, 4095);
                    2: semi = 32'h00FF_FFFF;
                    default: semi = $urandom >> $urandom_range(8, 31);
                endcase
                write_reg(rppg_pkg::CFG_SEMI_HEIGHT, semi);
            end
            if ($urandom_range(0, 2) == 0) write_reg(rppg_pkg::CFG_APEX_X, $urandom);
            if ($urandom_range(0, 2) == 0) write_reg(rppg_pkg::CFG_APEX_Y, $urandom);
            if ($urandom_range(0, 2) == 0) write_reg(rppg_pkg::CFG_APEX_Z, $urandom);
            burst = $urandom_range(10, 60);
            repeat (burst) begin
                send_request($urandom_range(0, 40) == 0);
                sent++;
            end
        end
    endtask

    // ring count above the limit, with no idling on either side
    task automatic test_ring_limit_no_idle();
        drain_points();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        write_reg(rppg_pkg::CFG_RING_COUNT, 32'd63);
        write_reg(rppg_pkg::CFG_SEMI_HEIGHT, 32'h00FF_FFFF);
        write_reg(rppg_pkg::CFG_APEX_X, $urandom);
        write_reg(rppg_pkg::CFG_APEX_Y, $urandom);
        write_reg(rppg_pkg::CFG_APEX_Z, $urandom);
        send_request(1'b1);
        repeat (40) send_request(1'b0);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_points
        t_pupil_point got;
        t_pupil_point want;
        string want_s;
        string got_s;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[31:0];
            got.y = o_m_tdata[63:32];
            got.z = o_m_tdata[95:64];
            got.ring = o_m_tdata[101:96];
            got.deg = o_m_tdata[110:102];
            got.is_last = o_m_tlast;
            if (pending_points.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected point x=%h y=%h ring=%0d deg=%0d",
                             got.x, got.y, got.ring, got.deg);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        want_s = $sformatf("x=%h y=%h z=%h ring=%0d deg=%0d last=%b",
                                           want.x, want.y, want.z, want.ring, want.deg,
                                           want.is_last);
                        got_s = $sformatf("x=%h y=%h z=%h ring=%0d deg=%0d last=%b",
                                          got.x, got.y, got.z, got.ring, got.deg,
                                          got.is_last);
                        $display("point mismatch: expected %s, got %s", want_s, got_s);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_reset_defaults();
        test_single_ring();
        test_zero_rings();
        test_semi_latch();
        test_lowered_rings();
        test_random_patterns();
        test_ring_limit_no_idle();
        drain_points();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_points.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
